### sv/qmc_pkg.sv
// qmc_pkg: shared types and constants for the qubit measure/collapse unit.
// No dependencies.
`default_nettype none
package qmc_pkg;
    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ = 2'd1,
        FUNC_MEASURE = 2'd2,
        FUNC_POSTSELECT = 2'd3
    } func_t;

    localparam int unsigned PROB_W = 17;
    localparam int unsigned FACTOR_W = 25;
    localparam logic [PROB_W-1:0] ONE_Q16 = 17'd65536;

    // Controller to datapath.
    typedef struct packed {
        logic load;        // capture input beat
        logic clr_sum;     // clear accumulators
        logic acc_en;      // accumulate current read word
        logic pick;        // choose outcome and probability
        logic div_start;   // start 2^48/p division
        logic sqrt_start;  // start square root
        logic wr_scale;    // write scaled/cleared word
        logic rd_en;       // issue memory read at sweep index (input address when do_read)
        logic idx_clr;     // reset sweep index
        logic idx_inc;     // advance sweep index
        logic do_write;    // write input amplitude
        logic do_read;     // read at input address, not the sweep index
        logic out_load;    // load result register
    } qmc_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic idx_last;
        logic div_done;
        logic sqrt_done;
        logic prob_zero;
    } qmc_stat_t;
endpackage
`default_nettype wire

### sv/qmc_datapath.sv
// qmc_datapath: amplitude memory, probability accumulators, divider,
// square root and scaler. Depends on qmc_pkg.
`default_nettype none
module qmc_datapath #(
    parameter int unsigned NUM_QUBITS = 10,
    parameter int unsigned AMP_WIDTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire qmc_pkg::qmc_cmd_t    cmd,
    output qmc_pkg::qmc_stat_t        stat,
    input  wire logic [1:0]           func,
    input  wire logic [9:0]           address,
    input  wire logic signed [15:0]   amp_real,
    input  wire logic signed [15:0]   amp_imag,
    input  wire logic [3:0]           target,
    input  wire logic                 wanted_outcome,
    input  wire logic [15:0]          random_value,
    output logic                      result_bit,
    output logic [16:0]               probability,
    output logic signed [15:0]        read_real,
    output logic signed [15:0]        read_imag,
    output logic                      status
);
    import qmc_pkg::*;

    localparam int unsigned DIM = 1 << NUM_QUBITS;
    localparam int unsigned SQ_W = 2 * AMP_WIDTH;
    localparam int SUM_SH = 2 * (AMP_WIDTH - 1) - 16;

    logic signed [AMP_WIDTH-1:0] mem_re [DIM];
    logic signed [AMP_WIDTH-1:0] mem_im [DIM];

    logic [1:0]             func_reg;
    logic [NUM_QUBITS-1:0]  addr_reg;
    logic signed [15:0]     wre_reg, wim_reg;
    logic [3:0]             target_reg;
    logic                   want_reg;
    logic [15:0]            rnd_reg;

    logic [NUM_QUBITS-1:0]  idx_reg, ridx_reg;
    logic signed [AMP_WIDTH-1:0] rre_reg, rim_reg;
    logic [SQ_W-1:0]        sqr_reg, sqi_reg;
    logic [NUM_QUBITS-1:0]  sidx_reg;
    logic                   sq_vld_reg, rd_vld_reg;
    logic [63:0]            sum0_reg, sum1_reg;
    logic                   bit_reg;
    logic [PROB_W-1:0]      prob_reg;
    logic [48:0]            rem_reg;
    logic [5:0]             dcnt_reg;
    logic                   dbusy_reg;
    logic [24:0]            root_reg;
    logic [4:0]             scnt_reg;
    logic                   sbusy_reg;

    // Input capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= func;
            addr_reg   <= NUM_QUBITS'(address);
            wre_reg    <= amp_real;
            wim_reg    <= amp_imag;
            target_reg <= target;
            want_reg   <= wanted_outcome;
            rnd_reg    <= random_value;
        end
    end

    function automatic logic signed [AMP_WIDTH-1:0] align_in(logic signed [15:0] v);
        logic signed [47:0] w;
        w = 48'(v);
        if (AMP_WIDTH >= 16)
            w = w <<< (AMP_WIDTH - 16);
        else
            w = w >>> (16 - AMP_WIDTH);
        return w[AMP_WIDTH-1:0];
    endfunction

    function automatic logic signed [15:0] align_out(logic signed [AMP_WIDTH-1:0] v);
        logic signed [47:0] w;
        w = 48'(v);
        if (AMP_WIDTH >= 16)
            w = w >>> (AMP_WIDTH - 16);
        else
            w = w <<< (16 - AMP_WIDTH);
        return w[15:0];
    endfunction

    function automatic logic hbit(logic [NUM_QUBITS-1:0] i, logic [3:0] t);
        logic [31:0] x;
        x = 32'(i) >> t;
        return x[0];
    endfunction

    function automatic logic [PROB_W-1:0] to_q16(logic [63:0] s);
        logic [64:0] p;
        if (SUM_SH > 0)
            p = 65'(s >> SUM_SH) + 65'((s >> (SUM_SH - 1)) & 64'd1);
        else
            p = 65'(s) << (-SUM_SH);
        if (p > 65'(ONE_Q16))
            p = 65'(ONE_Q16);
        return p[PROB_W-1:0];
    endfunction

    function automatic logic signed [AMP_WIDTH-1:0] scale(
        logic signed [AMP_WIDTH-1:0] a, logic [24:0] f);
        logic [AMP_WIDTH:0]      m;
        logic [AMP_WIDTH+25:0]   pr;
        logic [AMP_WIDTH+9:0]    r;
        logic [AMP_WIDTH+9:0]    lim;
        m = a[AMP_WIDTH-1] ? (AMP_WIDTH+1)'(-$signed({a[AMP_WIDTH-1], a}))
                           : (AMP_WIDTH+1)'(a);
        pr = (AMP_WIDTH+26)'(m) * (AMP_WIDTH+26)'(f) + (AMP_WIDTH+26)'(32768);
        r = pr[AMP_WIDTH+25:16];
        lim = (AMP_WIDTH+10)'(1) << (AMP_WIDTH - 1);
        if (a[AMP_WIDTH-1])
        begin
            if (r > lim)
                r = lim;
            return AMP_WIDTH'(-r);
        end
        if (r > lim - 1'b1)
            r = lim - 1'b1;
        return AMP_WIDTH'(r);
    endfunction

    // Memory: one write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.do_write)
        begin
            mem_re[addr_reg] <= align_in(wre_reg);
            mem_im[addr_reg] <= align_in(wim_reg);
        end
        else if (cmd.wr_scale && rd_vld_reg)
        begin
            if (hbit(ridx_reg, target_reg) == bit_reg)
            begin
                mem_re[ridx_reg] <= scale(rre_reg, root_reg);
                mem_im[ridx_reg] <= scale(rim_reg, root_reg);
            end
            else
            begin
                mem_re[ridx_reg] <= '0;
                mem_im[ridx_reg] <= '0;
            end
        end
        if (cmd.rd_en)
        begin
            rre_reg  <= mem_re[cmd.do_read ? addr_reg : idx_reg];
            rim_reg  <= mem_im[cmd.do_read ? addr_reg : idx_reg];
            ridx_reg <= idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
            sq_vld_reg <= 1'b0;
            dbusy_reg  <= 1'b0;
            sbusy_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;
            rd_vld_reg <= cmd.rd_en && !cmd.do_read;
            sq_vld_reg <= cmd.acc_en && rd_vld_reg;
            if (cmd.div_start)
                dbusy_reg <= 1'b1;
            else if (dcnt_reg == 6'd0)
                dbusy_reg <= 1'b0;
            if (cmd.sqrt_start)
                sbusy_reg <= 1'b1;
            else if (scnt_reg == 5'd0)
                sbusy_reg <= 1'b0;
        end
    end

    // Square stage then accumulate.
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            sqr_reg  <= SQ_W'($signed(rre_reg) * $signed(rre_reg));
            sqi_reg  <= SQ_W'($signed(rim_reg) * $signed(rim_reg));
            sidx_reg <= ridx_reg;
        end
    end

    logic [64:0] term, nsum;
    logic [63:0] tsat;
    always_comb
    begin
        term = 65'(sqr_reg) + 65'(sqi_reg);
        tsat = term[64] ? '1 : term[63:0];
        nsum = 65'(hbit(sidx_reg, target_reg) ? sum1_reg : sum0_reg) + 65'(tsat);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_sum)
        begin
            sum0_reg <= '0;
            sum1_reg <= '0;
        end
        else if (sq_vld_reg)
        begin
            if (hbit(sidx_reg, target_reg))
                sum1_reg <= nsum[64] ? '1 : nsum[63:0];
            else
                sum0_reg <= nsum[64] ? '1 : nsum[63:0];
        end
    end

    logic       bit_pick;
    logic [PROB_W-1:0] p0;
    always_comb
    begin
        p0 = to_q16(sum0_reg);
        if (func_reg == FUNC_MEASURE)
            bit_pick = !(17'(rnd_reg) < p0);
        else
            bit_pick = want_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pick)
        begin
            bit_reg  <= bit_pick;
            prob_reg <= bit_pick ? to_q16(sum1_reg) : p0;
        end
    end

    // Restoring division 2^48 / p, one quotient bit a cycle. p lies in 1..2^16,
    // so the quotient lies in 2^32..2^48: keep 49 bits.
    logic [48:0] quo_full_reg;
    logic [17:0] dr_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dr_reg       <= '0;
            quo_full_reg <= 49'd1 << 48;
            dcnt_reg     <= 6'd49;
        end
        else if (dbusy_reg && dcnt_reg != 6'd0)
        begin
            // shift next dividend bit in
            if ({dr_reg[16:0], quo_full_reg[48]} >= 18'(prob_reg))
            begin
                dr_reg       <= {dr_reg[16:0], quo_full_reg[48]} - 18'(prob_reg);
                quo_full_reg <= {quo_full_reg[47:0], 1'b1};
            end
            else
            begin
                dr_reg       <= {dr_reg[16:0], quo_full_reg[48]};
                quo_full_reg <= {quo_full_reg[47:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    // Square root: 25 steps, one candidate bit each.
    logic [24:0] cand;
    logic [49:0] csq;
    always_comb
    begin
        cand = root_reg | (25'd1 << scnt_reg);
        csq  = 50'(cand) * 50'(cand);
    end
    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            root_reg <= '0;
            scnt_reg <= 5'd24;
            rem_reg  <= quo_full_reg;
        end
        else if (sbusy_reg)
        begin
            if (csq <= 50'(rem_reg))
                root_reg <= cand;
            if (scnt_reg != 5'd0)
                scnt_reg <= scnt_reg - 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (func_reg == FUNC_READ)
            begin
                result_bit  <= 1'b0;
                probability <= '0;
                read_real   <= align_out(rre_reg);
                read_imag   <= align_out(rim_reg);
                status      <= 1'b0;
            end
            else if (func_reg == FUNC_WRITE)
            begin
                result_bit  <= 1'b0;
                probability <= '0;
                read_real   <= '0;
                read_imag   <= '0;
                status      <= 1'b0;
            end
            else
            begin
                result_bit  <= bit_reg;
                probability <= prob_reg;
                read_real   <= '0;
                read_imag   <= '0;
                status      <= (prob_reg == '0);
            end
        end
    end

    assign stat.idx_last  = (idx_reg == NUM_QUBITS'(DIM - 1));
    assign stat.div_done  = dbusy_reg && (dcnt_reg == 6'd0) && !cmd.div_start;
    assign stat.sqrt_done = sbusy_reg && (scnt_reg == 5'd0) && !cmd.sqrt_start;
    assign stat.prob_zero = (prob_reg == '0);

`ifndef SYNTHESIS
    a_div_sqrt_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(dbusy_reg && sbusy_reg && !cmd.sqrt_start)) else $error("div and sqrt overlap");
    a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.do_write && cmd.wr_scale)) else $error("write conflict");
    a_sq_follows: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld_reg |-> $past(rd_vld_reg)) else $error("square without read");
`endif
endmodule
`default_nettype wire

### sv/qmc_ctrl.sv
// qmc_ctrl: sequencer for write, read, measure and postselect.
// Depends on qmc_pkg.
`default_nettype none
module qmc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               valid,
    output logic                    ready,
    input  wire logic [1:0]         func,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output qmc_pkg::qmc_cmd_t       cmd,
    input  wire qmc_pkg::qmc_stat_t stat
);
    import qmc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_RD_WAIT, S_SUM, S_DRAIN1, S_DRAIN2, S_DRAIN3,
        S_PICK, S_DIV, S_SQRT, S_COLL, S_COLL_LAST, S_RESULT, S_HOLD
    } state_t;

    state_t     state_reg;
    logic [1:0] func_reg;
    logic       out_valid_reg;

    assign ready     = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.load = valid && ready;
        unique case (state_reg)
            S_IDLE: cmd.idx_clr = 1'b1;
            S_DISPATCH:
            begin
                if (func_reg == FUNC_WRITE)
                    cmd.do_write = 1'b1;
                else if (func_reg == FUNC_READ)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.do_read = 1'b1;
                end
                else
                    cmd.clr_sum = 1'b1;
            end
            S_RD_WAIT: ;
            S_SUM:
            begin
                cmd.rd_en   = 1'b1;
                cmd.acc_en  = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            S_DRAIN1, S_DRAIN2: cmd.acc_en = 1'b1;
            S_DRAIN3: ;
            S_PICK: cmd.pick = 1'b1;
            S_DIV:
            begin
                cmd.idx_clr = 1'b1;
                cmd.div_start = 1'b0;
            end
            S_SQRT: ;
            S_COLL:
            begin
                cmd.rd_en    = 1'b1;
                cmd.idx_inc  = 1'b1;
                cmd.wr_scale = 1'b1;
            end
            S_COLL_LAST: cmd.wr_scale = 1'b1;
            S_RESULT: cmd.out_load = 1'b1;
            S_HOLD: ;
            default: ;
        endcase
    end

    logic div_go, sqrt_go;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            func_reg      <= FUNC_WRITE;
            out_valid_reg <= 1'b0;
            div_go        <= 1'b0;
            sqrt_go       <= 1'b0;
        end
        else
        begin
            div_go  <= 1'b0;
            sqrt_go <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (valid)
                    begin
                        func_reg  <= func;
                        state_reg <= S_DISPATCH;
                    end
                S_DISPATCH:
                    priority if (func_reg == FUNC_WRITE)
                        state_reg <= S_RESULT;
                    else if (func_reg == FUNC_READ)
                        state_reg <= S_RD_WAIT;
                    else
                        state_reg <= S_SUM;
                S_RD_WAIT: state_reg <= S_RESULT;
                S_SUM:
                    if (stat.idx_last)
                        state_reg <= S_DRAIN1;
                S_DRAIN1: state_reg <= S_DRAIN2;
                S_DRAIN2: state_reg <= S_DRAIN3;
                S_DRAIN3: state_reg <= S_PICK;
                S_PICK: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (stat.prob_zero)
                        state_reg <= S_RESULT;
                    else
                    begin
                        div_go    <= 1'b1;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (stat.div_done && !div_go)
                        sqrt_go <= 1'b1;
                    if (stat.sqrt_done && !sqrt_go)
                        state_reg <= S_COLL;
                end
                S_COLL:
                    if (stat.idx_last)
                        state_reg <= S_COLL_LAST;
                S_COLL_LAST: state_reg <= S_RESULT;
                S_RESULT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_HOLD;
                end
                S_HOLD:
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_HOLD) else $error("out_valid outside hold");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready |-> !out_valid) else $error("ready while result pending");
    a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RESULT |=> out_valid) else $error("result not shown");
`endif
endmodule
`default_nettype wire

### sv/qubit_measure_collapse_unit.sv
// Qubit measure/collapse unit.
// Channels: input beat (valid/ready) carries func, address, amplitude,
// target, wanted_outcome and random_value; output beat (out_valid/out_ready)
// carries result_bit, probability, read_real, read_imag and status.
// Exactly one result beat per input beat.
// Measure and postselect sweep the state vector twice through the memory,
// with a 49-step divider and a 25-step square root between the sweeps;
// when the chosen probability is zero, only the first sweep runs.
// One item is in flight at a time; ready is high only while idle, so the
// next beat is taken at the earliest in the cycle after the result beat.
// Reset clears control state only; amplitude contents are undefined until
// written. A stalled receiver holds the result and the block takes no new
// beat until it is taken.
`default_nettype none
module qubit_measure_collapse_unit #(
    parameter int unsigned NUM_QUBITS = 10,
    parameter int unsigned AMP_WIDTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               valid,
    output logic                    ready,
    input  wire logic [1:0]         func,
    input  wire logic [9:0]         address,
    input  wire logic signed [15:0] amp_real,
    input  wire logic signed [15:0] amp_imag,
    input  wire logic [3:0]         target,
    input  wire logic               wanted_outcome,
    input  wire logic [15:0]        random_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    result_bit,
    output logic [16:0]             probability,
    output logic signed [15:0]      read_real,
    output logic signed [15:0]      read_imag,
    output logic                    status
);
    import qmc_pkg::*;

    qmc_cmd_t  cmd_raw, cmd;
    qmc_stat_t stat;
    logic      div_pulse_reg, sqrt_pulse_reg;
    logic      div_done_d_reg;

    qmc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .valid(valid), .ready(ready), .func(func),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd_raw), .stat(stat)
    );

    // Derive one-cycle start pulses for the iterative units.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_pulse_reg  <= 1'b0;
            sqrt_pulse_reg <= 1'b0;
            div_done_d_reg <= 1'b0;
        end
        else
        begin
            div_pulse_reg  <= cmd_raw.pick;
            div_done_d_reg <= stat.div_done;
            sqrt_pulse_reg <= stat.div_done && !div_done_d_reg;
        end
    end

    always_comb
    begin
        cmd = cmd_raw;
        cmd.div_start  = div_pulse_reg && !stat.prob_zero;
        cmd.sqrt_start = sqrt_pulse_reg;
    end

    qmc_datapath #(.NUM_QUBITS(NUM_QUBITS), .AMP_WIDTH(AMP_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .func(func), .address(address), .amp_real(amp_real), .amp_imag(amp_imag),
        .target(target), .wanted_outcome(wanted_outcome), .random_value(random_value),
        .result_bit(result_bit), .probability(probability), .read_real(read_real),
        .read_imag(read_imag), .status(status)
    );
endmodule
`default_nettype wire

### tb/tb_qubit_measure_collapse_unit.sv
// Self-checking testbench for qubit_measure_collapse_unit: random and directed beats,
// with every result checked against a predictor of the state vector held in the bench.
// Depends on qmc_pkg and the unit's RTL.
`timescale 1ns / 100ps
module tb_qubit_measure_collapse_unit;
    import qmc_pkg::*;

    localparam int DIM = 1024;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        func_t              func;
        logic [9:0]         addr;
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic [3:0]         targ;
        logic               wanted;
        logic [15:0]        rnd;
    } beat_t;

    typedef struct packed {
        logic               bit_out;
        logic [16:0]        prob;
        logic signed [15:0] rd_re;
        logic signed [15:0] rd_im;
        logic               zero_prob;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic valid = 1'b0;
    logic out_ready = 1'b0;
    logic ready, out_valid, result_bit, status;
    logic [16:0] probability;
    logic signed [15:0] read_real, read_imag;
    beat_t cur = '0;
    logic in_taken = 1'b0;

    beat_t    pending_beats[$];
    outcome_t expected_results[$];
    logic signed [15:0] state_re[DIM];
    logic signed [15:0] state_im[DIM];
    int errors = 0;
    int cycles = 0;
    int send_gap = 0;
    int stall_len = 0;
    bit calm_send = 0;
    bit calm_recv = 0;

    always #4 clk = ~clk;

    qubit_measure_collapse_unit u_top (
        .clk(clk), .rst_n(rst_n), .valid(valid), .ready(ready),
        .func(cur.func), .address(cur.addr), .amp_real(cur.re), .amp_imag(cur.im),
        .target(cur.targ), .wanted_outcome(cur.wanted), .random_value(cur.rnd),
        .out_valid(out_valid), .out_ready(out_ready), .result_bit(result_bit),
        .probability(probability), .read_real(read_real), .read_imag(read_imag),
        .status(status)
    );

    function automatic void add_beat(input beat_t b);
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    function automatic void add_expected(input outcome_t o);
        expected_results.insert(expected_results.size(), o);
    endfunction

    function automatic longint unsigned to_q16(input longint unsigned sum);
        longint unsigned p;
        p = (sum >> 14) + ((sum >> 13) & 1);
        return (p > 65536) ? 65536 : p;
    endfunction

    function automatic logic signed [15:0] scale_amp(input logic signed [15:0] a,
                                                    input longint unsigned f);
        longint unsigned mag, r;
        mag = (a < 0) ? longint'(-longint'(a)) : longint'(a);
        r = (mag * f + 32768) >> 16;
        if (a < 0)
            return (r > 32768) ? -16'sd32768 : 16'(-longint'(r));
        return (r > 32767) ? 16'sd32767 : 16'(r);
    endfunction

    // Apply one beat to the bench's copy of the state vector; return its result.
    function automatic outcome_t collapse_state(input beat_t b);
        outcome_t r;
        longint unsigned sums[2];
        longint unsigned p, x, root, cand;
        int h;
        r = '0;
        case (b.func)
            FUNC_WRITE:
            begin
                state_re[b.addr] = b.re;
                state_im[b.addr] = b.im;
            end
            FUNC_READ:
            begin
                r.rd_re = state_re[b.addr];
                r.rd_im = state_im[b.addr];
            end
            default:
            begin
                sums[0] = 0;
                sums[1] = 0;
                for (int i = 0; i < DIM; i++)
                begin
                    h = (i >> b.targ) & 1;
                    sums[h] += longint'(state_re[i]) * longint'(state_re[i])
                             + longint'(state_im[i]) * longint'(state_im[i]);
                end
                if (b.func == FUNC_MEASURE)
                    r.bit_out = (longint'(b.rnd) < to_q16(sums[0])) ? 1'b0 : 1'b1;
                else
                    r.bit_out = b.wanted;
                p = to_q16(sums[r.bit_out]);
                r.prob = p[16:0];
                if (p == 0)
                    r.zero_prob = 1'b1;
                else
                begin
                    x = (64'd1 << 48) / p;
                    root = 0;
                    for (int k = 24; k >= 0; k--)
                    begin
                        cand = root | (64'd1 << k);
                        if (cand * cand <= x)
                            root = cand;
                    end
                    for (int i = 0; i < DIM; i++)
                    begin
                        if (((i >> b.targ) & 1) == r.bit_out)
                        begin
                            state_re[i] = scale_amp(state_re[i], root);
                            state_im[i] = scale_amp(state_im[i], root);
                        end
                        else
                        begin
                            state_re[i] = '0;
                            state_im[i] = '0;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic beat_t mk(input func_t f, input int a, input int re, input int im,
                                 input int t, input int w, input int rv);
        beat_t b;
        b.func = f;
        b.addr = 10'(a);
        b.re = 16'(re);
        b.im = 16'(im);
        b.targ = 4'(t);
        b.wanted = 1'(w);
        b.rnd = 16'(rv);
        return b;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 2);
        return $urandom_range(10, 40);
    endfunction

    function automatic int rand_amp(input int shift);
        int m;
        m = $urandom_range(0, 32767 >> shift);
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    // Driver: hold the beat until taken, then advance after a random gap.
    always @(negedge clk)
    begin
        if (rst_n && (!valid || in_taken))
        begin
            if (send_gap > 0 && !calm_send)
            begin
                send_gap <= send_gap - 1;
                valid <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                cur <= pending_beats.pop_front();
                valid <= 1'b1;
                send_gap <= pick_gap();
                if ($urandom_range(0, 49) == 0)
                    calm_send <= ~calm_send;
            end
            else
                valid <= 1'b0;
        end
        if (rst_n)
        begin
            if (stall_len > 0 && !calm_recv)
            begin
                stall_len <= stall_len - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_len <= pick_gap();
                if ($urandom_range(0, 49) == 0)
                    calm_recv <= ~calm_recv;
            end
        end
    end

    // Monitor: check the result beat, then predict for an accepted input beat.
    always @(posedge clk)
    begin
        outcome_t e;
        in_taken <= valid && ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (result_bit !== e.bit_out)
                begin
                    $error("result_bit exp %0d got %0d", e.bit_out, result_bit);
                    errors++;
                end
                if (probability !== e.prob)
                begin
                    $error("probability exp %0d got %0d", e.prob, probability);
                    errors++;
                end
                if (read_real !== e.rd_re)
                begin
                    $error("read_real exp %0d got %0d", e.rd_re, read_real);
                    errors++;
                end
                if (read_imag !== e.rd_im)
                begin
                    $error("read_imag exp %0d got %0d", e.rd_im, read_imag);
                    errors++;
                end
                if (status !== e.zero_prob)
                begin
                    $error("status exp %0d got %0d", e.zero_prob, status);
                    errors++;
                end
            end
        end
        if (rst_n && valid && ready)
            add_expected(collapse_state(cur));
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("qubit_measure_collapse_unit test failed");
            $finish;
        end
    end

    initial
    begin
        int n, t, shift;
        func_t f;
        // Clear every entry first so no unwritten entry is ever read or swept.
        for (int i = 0; i < DIM; i++)
            add_beat(mk(FUNC_WRITE, i, 0, 0, 0, 0, 0));
        add_beat(mk(FUNC_WRITE, 0, 32767, -32768, 0, 0, 0));
        add_beat(mk(FUNC_WRITE, 1023, -32768, 32767, 0, 0, 0));
        add_beat(mk(FUNC_READ, 0, 0, 0, 0, 0, 0));
        add_beat(mk(FUNC_READ, 1023, 0, 0, 0, 0, 0));
        add_beat(mk(FUNC_READ, 5, 0, 0, 0, 0, 0));
        add_beat(mk(FUNC_MEASURE, 0, 0, 0, 0, 0, 0));
        add_beat(mk(FUNC_POSTSELECT, 0, 0, 0, 15, 1, 0));
        add_beat(mk(FUNC_POSTSELECT, 0, 0, 0, 0, 1, 0));
        add_beat(mk(FUNC_WRITE, 3, 16384, 16384, 0, 0, 0));
        add_beat(mk(FUNC_MEASURE, 0, 0, 0, 9, 0, 65535));
        add_beat(mk(FUNC_POSTSELECT, 0, 0, 0, 1, 1, 0));
        add_beat(mk(FUNC_READ, 3, 0, 0, 0, 0, 0));
        add_beat(mk(FUNC_READ, 0, 0, 0, 0, 0, 0));
        n = 0;
        while (n < 290)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                // Prepare a few amplitudes, collapse on them, read some back.
                shift = $urandom_range(0, 4);
                repeat ($urandom_range(1, 4))
                begin
                    add_beat(mk(FUNC_WRITE, $urandom_range(0, DIM - 1),
                        rand_amp(shift), rand_amp(shift), 0, 0, 0));
                    n++;
                end
                f = $urandom_range(0, 1) ? FUNC_MEASURE : FUNC_POSTSELECT;
                t = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
                add_beat(mk(f, 0, 0, 0, t, $urandom_range(0, 1),
                    $urandom_range(0, 65535)));
                n++;
                repeat ($urandom_range(0, 2))
                begin
                    add_beat(mk(FUNC_READ, $urandom_range(0, DIM - 1),
                        0, 0, 0, 0, 0));
                    n++;
                end
            end
            else
            begin
                add_beat(mk(func_t'($urandom_range(0, 3)),
                    $urandom_range(0, DIM - 1), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 15),
                    $urandom_range(0, 1), $urandom_range(0, 65535)));
                n++;
            end
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_beats.size() == 0 && !valid && expected_results.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("qubit_measure_collapse_unit test passed");
        else
            $display("qubit_measure_collapse_unit test failed");
        $finish;
    end
endmodule

### sim.f
sv/qmc_pkg.sv
sv/qmc_datapath.sv
sv/qmc_ctrl.sv
sv/qubit_measure_collapse_unit.sv
tb/tb_qubit_measure_collapse_unit.sv
